// ===== src/zero_crossing_frequency_estimator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the zero crossing frequency estimator
// Clocked property checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_FREQUENCY_ESTIMATOR_ASSERT_SVH
`define ZERO_CROSSING_FREQUENCY_ESTIMATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ZCFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ZCFE_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ZCFE_ASSERT(label, prop, msg)

`define ZCFE_NEVER(label, expr, msg)

`endif

`endif

// ===== src/zcfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcfe_pkg
// Shared types and constants of the zero crossing frequency estimator.
// ----------------------------------------------------------------------------
package zcfe_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 1024;
  localparam int SAMPLE_BITS_DEFAULT  = 10;

  localparam int MID_BITS       = 10;
  localparam int RATE_BITS      = 16;
  localparam int FREQ_BITS      = 19;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int STEP_BITS      = $clog2(FREQ_BITS);

  localparam logic [MID_BITS-1:0]  MIDPOINT_RESET = MID_BITS'(392);
  localparam logic [RATE_BITS-1:0] RATE_RESET     = RATE_BITS'(40000);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIDPOINT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE     = CFG_INDEX_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } zcfe_state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic out_load;
  } zcfe_cmd_t;

  typedef struct packed {
    logic out_free;
  } zcfe_status_t;

endpackage

// ===== src/zcfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcfe_ctrl
// Sequencer: takes samples, runs the divider at batch end, hands off result.
// ----------------------------------------------------------------------------
`include "zero_crossing_frequency_estimator_assert.svh"

module zcfe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  last_sample,
  output logic                  in_ready,
  input  zcfe_pkg::zcfe_status_t status,
  output zcfe_pkg::zcfe_cmd_t   cmd
);
  import zcfe_pkg::*;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FREQ_BITS - 1);

  zcfe_state_t state, state_next;
  logic [STEP_BITS-1:0] step_cnt, step_cnt_next;
  logic accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    unique case (state)
      ST_IDLE: begin
        step_cnt_next = '0;
        if (accept && last_sample) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_cnt == STEP_LAST) begin
          state_next    = ST_HOLD;
          step_cnt_next = '0;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_HOLD: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.start  = in_valid && last_sample;
      end
      ST_DIVIDE: cmd.step     = 1'b1;
      ST_HOLD:   cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  `ZCFE_ASSERT(a_last_starts_divide,
    (accept && last_sample) |=> (state == ST_DIVIDE), "last transfer did not start divide")
  `ZCFE_ASSERT(a_divide_length,
    (state == ST_DIVIDE && step_cnt == STEP_LAST) |=> (state == ST_HOLD),
    "divide did not finish after all quotient bits")
  `ZCFE_NEVER(a_step_range, step_cnt > STEP_LAST, "step counter overran")

endmodule

// ===== src/zcfe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcfe_datapath
// Crossing detection, slot bookkeeping, bit-serial divider, output register.
// ----------------------------------------------------------------------------
`include "zero_crossing_frequency_estimator_assert.svh"

module zcfe_datapath #(
  parameter int BUFFER_DEPTH = zcfe_pkg::BUFFER_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS  = zcfe_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [zcfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [zcfe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                last_sample,
  input  zcfe_pkg::zcfe_cmd_t                 cmd,
  output zcfe_pkg::zcfe_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [zcfe_pkg::FREQ_BITS-1:0]      frequency_q4,
  output logic                                estimate_valid
);
  import zcfe_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int MW = (SAMPLE_BITS > MID_BITS) ? SAMPLE_BITS : MID_BITS;
  localparam logic [PW-1:0] POS_MAX = PW'(BUFFER_DEPTH - 1);
  localparam logic [MW-1:0] SAMPLE_MASK = MW'({SAMPLE_BITS{1'b1}});

  logic [MID_BITS-1:0]    midpoint_level;
  logic [RATE_BITS-1:0]   sample_rate_hz;
  logic [SAMPLE_BITS-1:0] previous_sample;
  logic                   have_previous;
  logic [PW-1:0]          sample_position;
  logic [PW-1:0]          crossing_slot_a, crossing_slot_b;
  logic                   next_slot;
  logic [1:0]             crossings_seen;

  logic [PW-1:0]          slot_a_next, slot_b_next, gap;
  logic [1:0]             seen_next;
  logic [MW-1:0]          mid_w;
  logic                   crossing;

  logic [FREQ_BITS-1:0]   quo;
  logic [PW:0]            rem, rem_shift;
  logic [PW-1:0]          divisor;
  logic                   est_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      midpoint_level <= MIDPOINT_RESET;
      sample_rate_hz <= RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIDPOINT: midpoint_level <= cfg_data[MID_BITS-1:0];
        CFG_RATE:     sample_rate_hz <= cfg_data[RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign mid_w    = MW'(midpoint_level) & SAMPLE_MASK;
  assign crossing = have_previous &&
                    ((MW'(previous_sample) >= mid_w) != (MW'(sample) >= mid_w));

  always_comb begin
    slot_a_next = crossing_slot_a;
    slot_b_next = crossing_slot_b;
    seen_next   = crossings_seen;
    if (crossing) begin
      if (!next_slot) slot_a_next = sample_position;
      else            slot_b_next = sample_position;
      if (crossings_seen != 2'd2) seen_next = crossings_seen + 2'd1;
    end
    gap = (slot_a_next > slot_b_next) ? slot_a_next - slot_b_next
                                      : slot_b_next - slot_a_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && last_sample)) begin
      previous_sample <= '0;
      have_previous   <= 1'b0;
      sample_position <= '0;
      crossing_slot_a <= '0;
      crossing_slot_b <= '0;
      next_slot       <= 1'b0;
      crossings_seen  <= '0;
    end else if (cmd.accept) begin
      previous_sample <= sample;
      have_previous   <= 1'b1;
      if (sample_position < POS_MAX) sample_position <= sample_position + 1'b1;
      crossing_slot_a <= slot_a_next;
      crossing_slot_b <= slot_b_next;
      next_slot       <= next_slot ^ crossing;
      crossings_seen  <= seen_next;
    end
  end

  // restoring divide, one quotient bit per step
  assign rem_shift = {rem[PW-1:0], quo[FREQ_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo     <= {sample_rate_hz, 3'b000};
      rem     <= '0;
      divisor <= gap;
      est_ok  <= (seen_next == 2'd2) && (gap != '0);
    end else if (cmd.step) begin
      if (rem_shift >= {1'b0, divisor}) begin
        rem <= rem_shift - {1'b0, divisor};
        quo <= {quo[FREQ_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[FREQ_BITS-2:0], 1'b0};
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frequency_q4   <= est_ok ? quo : '0;
      estimate_valid <= est_ok;
    end
  end

  `ZCFE_NEVER(a_seen_sat, crossings_seen == 2'd3, "crossing count past saturation")
  `ZCFE_ASSERT(a_rem_bound, (cmd.step && divisor != '0) |=> (rem < {1'b0, divisor}),
    "divider remainder not below divisor")
  `ZCFE_NEVER(a_load_over_full, cmd.out_load && out_valid && !out_ready,
    "result loaded over an untaken result")

endmodule

// ===== src/zero_crossing_frequency_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_frequency_estimator
// Estimates signal frequency from midpoint crossings in a batch of samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block is idle. A sample flagged
// last_sample closes the batch and starts a restoring divider that produces
// one quotient bit per cycle; no sample is taken until the result sits in
// the output register, and the next batch may start as soon as it does,
// even while the result waits to be taken.
// frequency_q4 = floor(sample_rate_hz * 8 / gap), with gap the distance of
// the last two crossing positions; estimate_valid is low with a zero result
// when fewer than two crossings were seen or the gap is zero.
module zero_crossing_frequency_estimator #(
  parameter int BUFFER_DEPTH = zcfe_pkg::BUFFER_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS  = zcfe_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [zcfe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [zcfe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [zcfe_pkg::FREQ_BITS-1:0]      frequency_q4,
  output logic                                estimate_valid
);
  import zcfe_pkg::*;

  zcfe_cmd_t    cmd;
  zcfe_status_t status;

  assign cfg_ready = 1'b1;

  zcfe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_sample (last_sample),
    .in_ready    (in_ready),
    .status      (status),
    .cmd         (cmd)
  );

  zcfe_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .last_sample    (last_sample),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frequency_q4   (frequency_q4),
    .estimate_valid (estimate_valid)
  );

endmodule

// ===== tb/sv/tb_zero_crossing_frequency_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for zero_crossing_frequency_estimator
// Drives sample batches and register writes over valid/ready channels. A
// scoreboard model tracks midpoint crossings and predicts the frequency
// estimate for every batch. Delivered estimates are checked in order, field
// by field, under random idle on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_zero_crossing_frequency_estimator;
  import zcfe_pkg::*;

  localparam int SMP_BITS    = SAMPLE_BITS_DEFAULT;
  localparam int DEPTH       = BUFFER_DEPTH_DEFAULT;
  localparam int POS_BITS    = $clog2(DEPTH);
  localparam int DRAIN_GAP   = 25;
  localparam int HOLD_CYCLES = 300;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = CFG_INDEX_BITS'(3);

  typedef struct packed {
    logic [FREQ_BITS-1:0] freq_q4;
    logic                 est_valid;
  } estimate_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [SMP_BITS-1:0]       sample;
  logic                      last_sample;
  logic                      out_valid;
  logic                      out_ready;
  logic [FREQ_BITS-1:0]      frequency_q4;
  logic                      estimate_valid;

  // scoreboard model state
  logic [MID_BITS-1:0]  mid_level;
  logic [RATE_BITS-1:0] rate_hz;
  logic [SMP_BITS-1:0]  prev_smp;
  logic                 have_prev;
  logic [POS_BITS-1:0]  pos;
  logic [POS_BITS-1:0]  slot_a;
  logic [POS_BITS-1:0]  slot_b;
  logic                 slot_sel;
  logic [1:0]           n_cross;

  estimate_t pending_estimates[$];

  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  int hold_off_left = 0;
  int mismatches    = 0;
  int items_sent    = 0;
  int batches_sent  = 0;
  int valid_expected = 0;
  int results_seen  = 0;
  int config_writes = 0;

  zero_crossing_frequency_estimator #(
    .BUFFER_DEPTH(DEPTH),
    .SAMPLE_BITS (SMP_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .last_sample   (last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frequency_q4  (frequency_q4),
    .estimate_valid(estimate_valid)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("MISMATCH @%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    mismatches++;
  endtask

  task automatic restart_batch();
    prev_smp  = '0;
    have_prev = 1'b0;
    pos       = '0;
    slot_a    = '0;
    slot_b    = '0;
    slot_sel  = 1'b0;
    n_cross   = '0;
  endtask

  // Advance the crossing tracker by one transferred sample.
  task automatic track_crossings(input logic [SMP_BITS-1:0] s, input logic l);
    logic        prev_hi;
    logic        cur_hi;
    int unsigned gap;
    estimate_t   est;
    if (have_prev) begin
      prev_hi = prev_smp >= mid_level;
      cur_hi  = s >= mid_level;
      if (prev_hi != cur_hi) begin
        if (!slot_sel) slot_a = pos;
        else slot_b = pos;
        slot_sel = ~slot_sel;
        if (n_cross < 2) n_cross++;
      end
    end
    prev_smp  = s;
    have_prev = 1'b1;
    if (pos < DEPTH - 1) pos++;
    items_sent++;
    if (l) begin
      gap = (slot_a > slot_b) ? slot_a - slot_b : slot_b - slot_a;
      est = '0;
      if (n_cross >= 2 && gap != 0) begin
        est.freq_q4   = FREQ_BITS'((int'(rate_hz) * 8) / gap);
        est.est_valid = 1'b1;
        valid_expected++;
      end
      pending_estimates.push_back(est);
      batches_sent++;
      restart_batch();
    end
  endtask

  // Called and returns at a falling edge.
  task automatic offer_sample(input logic [SMP_BITS-1:0] s, input logic l);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= l;
    do @(posedge clk); while (!in_ready);
    track_crossings(s, l);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIDPOINT: mid_level = data[MID_BITS-1:0];
      CFG_RATE:     rate_hz = data;
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  function automatic logic [SMP_BITS-1:0] level_above();
    return SMP_BITS'($urandom_range(int'(mid_level), (1 << SMP_BITS) - 1));
  endfunction

  function automatic logic [SMP_BITS-1:0] level_below();
    if (mid_level == 0) return level_above();
    return SMP_BITS'($urandom_range(0, int'(mid_level) - 1));
  endfunction

  // Mostly square-ish waves around the midpoint, some noise, some flat.
  task automatic send_random_batch(input int max_len, output int len);
    int   mode;
    int   half;
    logic hi;
    logic [SMP_BITS-1:0] s;
    len  = ($urandom_range(0, 29) == 0) ? $urandom_range(41, 64)
                                        : $urandom_range(1, max_len);
    mode = $urandom_range(0, 9);
    half = $urandom_range(1, 12);
    hi   = 1'($urandom_range(0, 1));
    for (int k = 0; k < len; k++) begin
      if (mode < 7) begin
        if (k != 0 && $urandom_range(1, half) == 1) hi = ~hi;
        s = hi ? level_above() : level_below();
      end else if (mode < 9) begin
        s = SMP_BITS'($urandom_range(0, (1 << SMP_BITS) - 1));
      end else begin
        s = level_above();
      end
      offer_sample(s, k == len - 1);
    end
  endtask

  task automatic test_reset_defaults();
    offer_sample(10'd100, 1'b0);
    offer_sample(10'd500, 1'b0);
    offer_sample(10'd500, 1'b0);
    offer_sample(10'd100, 1'b1);
  endtask

  task automatic test_directed_edges();
    wait_drain();
    write_register(CFG_MIDPOINT, 16'hFC00 | 16'd512);
    write_register(CFG_RATE, 16'hFFFF);
    write_register(CFG_SPARE_2, 16'hFFFF);
    write_register(CFG_SPARE_3, 16'h0000);
    // single-sample batch
    offer_sample(10'd1023, 1'b1);
    // one crossing only
    offer_sample(10'd0, 1'b0);
    offer_sample(10'd1023, 1'b1);
    // adjacent crossings at full rate: largest estimate
    offer_sample(10'd0, 1'b0);
    offer_sample(10'd1023, 1'b0);
    offer_sample(10'd0, 1'b1);
    // samples on the midpoint count as high
    offer_sample(10'd511, 1'b0);
    offer_sample(10'd512, 1'b0);
    offer_sample(10'd511, 1'b0);
    offer_sample(10'd512, 1'b1);
    wait_drain();
    write_register(CFG_RATE, 16'd1);
    write_register(CFG_MIDPOINT, 16'd1023);
    offer_sample(10'd1023, 1'b0);
    offer_sample(10'd1022, 1'b0);
    offer_sample(10'd1022, 1'b0);
    offer_sample(10'd1022, 1'b0);
    offer_sample(10'd1023, 1'b1);
    wait_drain();
    write_register(CFG_MIDPOINT, 16'd0);
    offer_sample(10'd0, 1'b0);
    offer_sample(10'd1023, 1'b0);
    offer_sample(10'd0, 1'b1);
  endtask

  // Batch longer than the buffer: positions pin at the top.
  task automatic test_saturated_position();
    wait_drain();
    write_register(CFG_MIDPOINT, 16'd512);
    write_register(CFG_RATE, CFG_DATA_BITS'($urandom_range(1, 65535)));
    // both crossings land on the pinned position: zero gap
    for (int k = 0; k < DEPTH - 1; k++) offer_sample(level_below(), 1'b0);
    offer_sample(level_above(), 1'b0);
    offer_sample(level_below(), 1'b0);
    offer_sample(level_below(), 1'b1);
  endtask

  task automatic test_random_batches();
    int len;
    int phase_items;
    logic [MID_BITS-1:0]  mid;
    logic [RATE_BITS-1:0] rate;
    for (int p = 0; p < 6; p++) begin
      wait_drain();
      case (p)
        0:       mid = '0;
        1:       mid = '1;
        default: mid = MID_BITS'($urandom_range(1, 1022));
      endcase
      case (p)
        2:       rate = 16'd1;
        3:       rate = 16'hFFFF;
        default: rate = RATE_BITS'($urandom_range(1, 65535));
      endcase
      write_register(CFG_MIDPOINT, {6'($urandom), mid});
      write_register(CFG_RATE, rate);
      if ($urandom_range(0, 1) == 0)
        write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                       CFG_DATA_BITS'($urandom));
      phase_items = 0;
      while (phase_items < 10) begin
        send_random_batch(8, len);
        phase_items += len;
      end
    end
  endtask

  // Output held off while short batches keep coming.
  task automatic test_output_hold();
    int len;
    wait_drain();
    write_register(CFG_MIDPOINT, 16'd300);
    write_register(CFG_RATE, 16'd48000);
    hold_off_left = HOLD_CYCLES;
    for (int b = 0; b < 8; b++) send_random_batch(6, len);
  endtask

  task automatic test_no_idle_tail();
    int len;
    int tail_items;
    wait_drain();
    write_register(CFG_MIDPOINT, CFG_DATA_BITS'($urandom_range(0, 1023)));
    write_register(CFG_RATE, CFG_DATA_BITS'($urandom_range(1, 65535)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    tail_items = 0;
    while (tail_items < 20) begin
      send_random_batch(8, len);
      tail_items += len;
    end
  endtask

  initial begin : rx_side
    int burst;
    burst     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_estimates
    estimate_t exp_est;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_estimates.size() == 0) begin
        report_mismatch("estimate with no batch pending, frequency_q4", 0, frequency_q4);
      end else begin
        exp_est = pending_estimates.pop_front();
        if (frequency_q4 !== exp_est.freq_q4)
          report_mismatch("frequency_q4", exp_est.freq_q4, frequency_q4);
        if (estimate_valid !== exp_est.est_valid)
          report_mismatch("estimate_valid", exp_est.est_valid, estimate_valid);
      end
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    sample      = '0;
    last_sample = 1'b0;
    mid_level   = MIDPOINT_RESET;
    rate_hz     = RATE_RESET;
    restart_batch();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_directed_edges();
    test_saturated_position();
    test_random_batches();
    test_output_hold();
    test_no_idle_tail();

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_estimates.size() != 0; i++) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
    if (pending_estimates.size() != 0)
      report_mismatch("estimates never delivered", 0, pending_estimates.size());

    $display("Run covered %0d samples in %0d batches, %0d with a valid estimate,",
             items_sent, batches_sent, valid_expected);
    $display("%0d register writes, %0d estimates checked, %0d mismatches.",
             config_writes, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT @%0t with %0d estimates outstanding", $time,
             pending_estimates.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/zcfe_pkg.sv
src/zcfe_ctrl.sv
src/zcfe_datapath.sv
src/zero_crossing_frequency_estimator.sv
tb/sv/tb_zero_crossing_frequency_estimator.sv
